[rtl/nfam_pkg.sv]
// Package for the NFA active set matcher: field widths, command and register codes,
// the control state type and parameter defaults.
// No dependencies.
package nfam_pkg;

    // Default sizes of the automaton.
    localparam int NUM_STATES_DEF  = 32;
    localparam int NUM_SYMBOLS_DEF = 128;

    // Fixed field widths of the request and configuration ports.
    localparam int CMD_W    = 2;
    localparam int STATE_W  = 5;
    localparam int SYM_W    = 7;
    localparam int ACCEPT_W = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IX_W = 1;

    // Request commands.
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FEED   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IX_W-1:0] CFG_START  = 1'b0;
    localparam logic [CFG_IX_W-1:0] CFG_ACCEPT = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADD  = 4'b0010,
        ST_FEED = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

endpackage

[rtl/nfam_store.sv]
// Transition store of the NFA matcher: one synchronous memory with a registered
// read port, a write port and a clearing pass after reset. No package needed.
module nfam_store #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic              o_clearing
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_en;
    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_data;

    // The clearing pass owns the write port until every entry is zero.
    always_comb begin
        if (r_clr_busy) begin
            w_en   = 1'b1;
            w_addr = r_clr_addr;
            w_data = '0;
        end else begin
            w_en   = i_wr_en;
            w_addr = i_wr_addr;
            w_data = i_wr_data;
        end
    end

    // Clearing sweep, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_busy;

endmodule

[rtl/nfa_active_set_matcher.sv]
// NFA active set matcher. Add transition: read the set, then write back the extended set.
// Feed symbol: one transition store read per state through the single read port.
// Finish: waits while the result register is held; one request at a time.
// Synchronous active-low reset; afterwards a clearing pass over all
// 2**(clog2(NUM_STATES) + clog2(NUM_SYMBOLS)) store entries (4096 by default) holds o_in_stall high.
// Configuration writes are taken at all times.
module nfa_active_set_matcher #(
    parameter int NUM_STATES  = nfam_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = nfam_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [nfam_pkg::CMD_W-1:0]    i_command,
    input  logic [nfam_pkg::STATE_W-1:0]  i_source_state,
    input  logic [nfam_pkg::SYM_W-1:0]    i_symbol,
    input  logic [nfam_pkg::STATE_W-1:0]  i_target_state,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_accepted,
    output logic                          o_alive,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nfam_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic [nfam_pkg::CFG_W-1:0]    i_cfg_data
);

    import nfam_pkg::*;

    localparam int SW = $clog2(NUM_STATES);
    localparam int YW = $clog2(NUM_SYMBOLS);
    localparam int AW = SW + YW;
    localparam int CW = $clog2(NUM_STATES + 1);

    t_state                r_state;
    logic [STATE_W-1:0]    r_src;
    logic [SYM_W-1:0]      r_sym;
    logic [STATE_W-1:0]    r_dst;
    logic [CW-1:0]         r_cnt;
    logic                  r_rd_use;
    logic [NUM_STATES-1:0] r_acc;
    logic [NUM_STATES-1:0] r_active;
    logic [STATE_W-1:0]    r_start;
    logic [ACCEPT_W-1:0]   r_accept;
    logic                  r_out_valid;
    logic                  r_accepted;
    logic                  r_alive;

    logic                  in_acc;
    logic                  cfg_acc;
    logic                  out_free;
    logic                  clearing;
    logic                  scan_done;
    logic                  add_ok;
    logic                  sym_ok;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [NUM_STATES-1:0] wr_data;
    logic                  wr_en;
    logic [NUM_STATES-1:0] rd_data;
    logic [NUM_STATES-1:0] n_acc;
    logic [NUM_STATES-1:0] accept_ext;

    // Set holding only the given start state, empty when it lies beyond the automaton.
    function automatic logic [NUM_STATES-1:0] start_set(input logic [STATE_W-1:0] st);
        logic [NUM_STATES-1:0] s;
        s = '0;
        if (32'(st) < 32'(NUM_STATES)) begin
            s = NUM_STATES'(1) << st;
        end
        return s;
    endfunction

    // Handshakes.
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = clearing || (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Range checks for add and feed requests.
    assign add_ok = (32'(i_source_state) < 32'(NUM_STATES))
                 && (32'(i_target_state) < 32'(NUM_STATES))
                 && (32'(i_symbol) < 32'(NUM_SYMBOLS));
    assign sym_ok = 32'(r_sym) < 32'(NUM_SYMBOLS);

    // Read address: the scanned state row while feeding, else the entry of the requested source state and symbol.
    always_comb begin
        if (r_state == ST_FEED) begin
            rd_addr = {r_cnt[SW-1:0], YW'(r_sym)};
        end else begin
            rd_addr = {SW'(i_source_state), YW'(i_symbol)};
        end
    end

    // Write back of an extended transition set.
    assign wr_en   = (r_state == ST_ADD);
    assign wr_addr = {SW'(r_src), YW'(r_sym)};
    assign wr_data = rd_data | (NUM_STATES'(1) << r_dst);

    // Union of the sets read so far, including the one arriving this cycle.
    assign n_acc      = r_rd_use ? (r_acc | rd_data) : r_acc;
    assign scan_done  = (r_cnt == CW'(NUM_STATES));
    assign accept_ext = NUM_STATES'(r_accept);

    nfam_store #(
        .DATA_W (NUM_STATES),
        .ADDR_W (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .o_clearing (clearing)
    );

    // Request fields are held for the whole operation.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_src <= i_source_state;
            r_sym <= i_symbol;
            r_dst <= i_target_state;
        end
    end

    // Sequencer, active set and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rd_use    <= 1'b0;
            r_acc       <= '0;
            r_active    <= start_set('0);
            r_start     <= '0;
            r_accept    <= '0;
            r_out_valid <= 1'b0;
            r_accepted  <= 1'b0;
            r_alive     <= 1'b0;
        end else begin
            // In the finish state the result register is handled below.
            if (r_out_valid && !i_out_stall && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes; a new start state reloads the active set.
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_START: begin
                        r_start  <= i_cfg_data[STATE_W-1:0];
                        r_active <= start_set(i_cfg_data[STATE_W-1:0]);
                    end
                    CFG_ACCEPT: begin
                        r_accept <= i_cfg_data[ACCEPT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        unique case (i_command)
                            CMD_ADD: begin
                                if (add_ok) begin
                                    r_state <= ST_ADD;
                                end
                            end
                            CMD_FEED: begin
                                r_cnt    <= '0;
                                r_rd_use <= 1'b0;
                                r_acc    <= '0;
                                r_state  <= ST_FEED;
                            end
                            CMD_FINISH: begin
                                r_state <= ST_FIN;
                            end
                            CMD_NONE: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ADD: begin
                    r_state <= ST_IDLE;
                end
                ST_FEED: begin
                    // One row read per cycle; the read data arrives in the cycle after the read.
                    r_acc <= n_acc;
                    if (scan_done) begin
                        r_rd_use <= 1'b0;
                        r_active <= sym_ok ? n_acc : '0;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_rd_use <= r_active[r_cnt[SW-1:0]];
                        r_cnt    <= r_cnt + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_accepted  <= |(r_active & accept_ext);
                        r_alive     <= |r_active;
                        r_active    <= start_set(r_start);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_alive     = r_alive;

endmodule
